FILE: rtl/core/blt3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blt3_pkg: shared types and constants of the 3D line generator
// Coordinate and error widths, field layout of the streams, axis and
// operation codes, and the record passed from the input stage.
// ----------------------------------------------------------------------------
package blt3_pkg;

   // field width on the streams and internal coordinate width
   localparam int FieldBits = 16;
   localparam int CoordBits = 16;
   // twice a distance, and the signed error term
   localparam int DeltaBits = CoordBits + 1;
   localparam int ErrBits   = CoordBits + 3;

   localparam int ReqDataBits = 7 * FieldBits;
   localparam int RspDataBits = 4 * FieldBits;

   // operation codes carried in tuser
   localparam logic OpStart = 1'b0;
   localparam logic OpStep  = 1'b1;

   // axis codes
   typedef enum logic [1:0] {
      AxisX = 2'd0,
      AxisY = 2'd1,
      AxisZ = 2'd2
   } axis_type;

   typedef logic [CoordBits-1:0] coord_type;

   // input stage record: start point, distances and directions
   typedef struct packed {
      logic                     op;
      logic [2:0][CoordBits-1:0] start;
      logic [2:0][CoordBits-1:0] delta;
      logic [2:0]               down;
      logic [FieldBits-1:0]     symbol;
   } prep_type;

endpackage
`default_nettype wire

FILE: rtl/core/blt3_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blt3_prep: input register of the line generator
// Takes a request transfer, forms the absolute distance and direction of
// each axis, and holds the result until the stepping stage takes it.
// ----------------------------------------------------------------------------
module blt3_prep (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic                              in_op,
   input  wire logic [blt3_pkg::ReqDataBits-1:0]  in_data,
   output logic                                   in_ready,
   input  wire logic                              take,     // next stage takes the item
   output logic                                   out_valid,
   output blt3_pkg::prep_type                     out_prep
);

   logic                  valid_ff, valid_in;
   blt3_pkg::prep_type    prep_ff, prep_in;
   logic [2:0][blt3_pkg::CoordBits-1:0] s, e;

   assign in_ready = !valid_ff || take;

   // unpack endpoints and build distances
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s[k] = blt3_pkg::CoordBits'(in_data[k*blt3_pkg::FieldBits +: blt3_pkg::FieldBits]);
         e[k] = blt3_pkg::CoordBits'(in_data[(k+3)*blt3_pkg::FieldBits +: blt3_pkg::FieldBits]);
      end
      prep_in.op     = in_op;
      prep_in.start  = s;
      prep_in.symbol = in_data[6*blt3_pkg::FieldBits +: blt3_pkg::FieldBits];
      for (int k = 0; k < 3; k++) begin
         prep_in.down[k]  = e[k] < s[k];
         prep_in.delta[k] = prep_in.down[k] ? (s[k] - e[k]) : (e[k] - s[k]);
      end
   end

   // valid tracks what is held
   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prep_ff <= prep_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_prep  = prep_ff;

endmodule
`default_nettype wire

FILE: rtl/core/blt3_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blt3_step: line state and result register
// Starts a line (major axis, error terms, step count) or advances it by
// one point, and loads the emitted point into the result register.
// ----------------------------------------------------------------------------
module blt3_step (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire blt3_pkg::prep_type                in_prep,
   output logic                                   take,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [blt3_pkg::RspDataBits-1:0]       out_data,
   output logic                                   out_last
);

   typedef logic signed [blt3_pkg::ErrBits-1:0]   err_type;
   typedef logic [blt3_pkg::DeltaBits-1:0]        tdelta_type;

   // line state
   logic [2:0][blt3_pkg::CoordBits-1:0] cur_ff, cur_in;
   logic [2:0][blt3_pkg::DeltaBits-1:0] tdelta_ff, tdelta_in;
   logic [2:0]                          down_ff, down_in;
   blt3_pkg::axis_type                  major_ff, major_in;
   err_type                             err_ff [2];
   err_type                             err_in [2];
   blt3_pkg::coord_type                 left_ff, left_in;
   logic [blt3_pkg::FieldBits-1:0]      sym_ff, sym_in;
   logic                                busy_ff, busy_in;

   // result register
   logic                                rvalid_ff, rvalid_in;
   logic [blt3_pkg::RspDataBits-1:0]    rdata_ff, rdata_in;
   logic                                rlast_ff, rlast_in;

   logic                                fire, emit;
   blt3_pkg::axis_type                  smaj, mina, minb, cmina, cminb;
   blt3_pkg::coord_type                 dmaj;
   logic [1:0]                          pos;
   logic [2:0]                          move;
   blt3_pkg::coord_type                 left_dec;

   // minor axes of a given major axis, in axis order
   function automatic blt3_pkg::axis_type minor_lo(input blt3_pkg::axis_type m);
      return (m == blt3_pkg::AxisX) ? blt3_pkg::AxisY : blt3_pkg::AxisX;
   endfunction

   function automatic blt3_pkg::axis_type minor_hi(input blt3_pkg::axis_type m);
      return (m == blt3_pkg::AxisZ) ? blt3_pkg::AxisY : blt3_pkg::AxisZ;
   endfunction

   function automatic err_type ext(input tdelta_type v);
      return err_type'({2'b00, v});
   endfunction

   assign take = !rvalid_ff || out_ready;
   assign fire = take && in_valid;

   // major axis of a new line: x on ties, then y, else z
   always_comb begin
      if (in_prep.delta[0] >= in_prep.delta[1] && in_prep.delta[0] >= in_prep.delta[2]) begin
         smaj = blt3_pkg::AxisX;
      end else if (in_prep.delta[1] >= in_prep.delta[2]) begin
         smaj = blt3_pkg::AxisY;
      end else begin
         smaj = blt3_pkg::AxisZ;
      end
      mina = minor_lo(smaj);
      minb = minor_hi(smaj);
      dmaj = in_prep.delta[smaj];
   end

   // one step of the running line
   always_comb begin
      cmina    = minor_lo(major_ff);
      cminb    = minor_hi(major_ff);
      pos[0]   = err_ff[0] > 0;
      pos[1]   = err_ff[1] > 0;
      left_dec = left_ff - 1'b1;
      for (int a = 0; a < 3; a++) begin
         move[a] = (major_ff == blt3_pkg::axis_type'(a))
                || (pos[0] && cmina == blt3_pkg::axis_type'(a))
                || (pos[1] && cminb == blt3_pkg::axis_type'(a));
      end
   end

   // next state
   always_comb begin
      cur_in    = cur_ff;
      tdelta_in = tdelta_ff;
      down_in   = down_ff;
      major_in  = major_ff;
      err_in[0] = err_ff[0];
      err_in[1] = err_ff[1];
      left_in   = left_ff;
      sym_in    = sym_ff;
      busy_in   = busy_ff;
      emit      = 1'b0;
      if (fire) begin
         if (in_prep.op == blt3_pkg::OpStart) begin
            emit     = 1'b1;
            cur_in   = in_prep.start;
            down_in  = in_prep.down;
            major_in = smaj;
            sym_in   = in_prep.symbol;
            left_in  = dmaj;
            busy_in  = dmaj != '0;
            for (int k = 0; k < 3; k++) begin
               tdelta_in[k] = {in_prep.delta[k], 1'b0};
            end
            err_in[0] = ext({in_prep.delta[mina], 1'b0}) - ext({1'b0, dmaj});
            err_in[1] = ext({in_prep.delta[minb], 1'b0}) - ext({1'b0, dmaj});
         end else if (busy_ff) begin
            emit = 1'b1;
            for (int a = 0; a < 3; a++) begin
               if (move[a]) begin
                  cur_in[a] = down_ff[a] ? (cur_ff[a] - 1'b1) : (cur_ff[a] + 1'b1);
               end
            end
            err_in[0] = err_ff[0] - (pos[0] ? ext(tdelta_ff[major_ff]) : '0)
                      + ext(tdelta_ff[cmina]);
            err_in[1] = err_ff[1] - (pos[1] ? ext(tdelta_ff[major_ff]) : '0)
                      + ext(tdelta_ff[cminb]);
            left_in   = left_dec;
            busy_in   = left_dec != '0;
         end
      end
   end

   // result register load
   always_comb begin
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;
      rlast_in  = rlast_ff;
      if (take) begin
         rvalid_in = emit;
      end
      if (emit) begin
         rdata_in = {sym_in,
                     blt3_pkg::FieldBits'(cur_in[2]),
                     blt3_pkg::FieldBits'(cur_in[1]),
                     blt3_pkg::FieldBits'(cur_in[0])};
         rlast_in = !busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      tdelta_ff <= tdelta_in;
      down_ff   <= down_in;
      major_ff  <= major_in;
      err_ff[0] <= err_in[0];
      err_ff[1] <= err_in[1];
      left_ff   <= left_in;
      sym_ff    <= sym_in;
      rdata_ff  <= rdata_in;
      rlast_ff  <= rlast_in;
   end

   assign out_valid = rvalid_ff;
   assign out_data  = rdata_ff;
   assign out_last  = rlast_ff;

endmodule
`default_nettype wire

FILE: rtl/core/bresenham_line_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_3d: 3D Bresenham voxel line generator
// Request channel (req_): tuser selects start (0) or step (1); a start
// transfer carries both endpoints and a tile symbol in tdata.
// Result channel (rsp_): one point per start, and one per step while a
// line is running; tlast marks the line's end point. A step with no line
// running gives no result.
// From request transfer to result valid, a request passes the input
// register, then the stepping stage loads the result register.
// Throughput: one request per cycle while results are taken; error terms
// update with a couple of adds and compares per cycle in the stepping stage.
// When the receiver stalls, the result register holds and the input
// register fills; req_tready then drops until the result is taken.
// Reset clears the valid flags and ends any running line; no result is
// produced until a new request arrives.
// ----------------------------------------------------------------------------
module bresenham_line_3d (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // x_start, y_start, z_start, x_end, y_end, z_end, symbol (lowest first)
   input  wire logic [111:0] req_tdata,
   // op
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pt_x, pt_y, pt_z, mark (lowest first)
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tlast
);

   logic               prep_valid;
   logic               take;
   blt3_pkg::prep_type prep;

   // input register and distance stage
   blt3_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_op     (req_tuser[0]),
      .in_data   (req_tdata),
      .in_ready  (req_tready),
      .take      (take),
      .out_valid (prep_valid),
      .out_prep  (prep)
   );

   // line state and result register
   blt3_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_prep   (prep),
      .take      (take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: rtl/core/blt3_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blt3_checker: port checks of the line generator
// Request and result hold under stall, reset behavior and result latency.
// ----------------------------------------------------------------------------
module blt3_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [111:0] req_tdata,
   input wire logic [0:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata,
   input wire logic         rsp_tlast
);

   // a waiting request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request changed while waiting");

   // a stalled result stays valid
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a new result needs a request transfer through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching request");

endmodule

bind bresenham_line_3d blt3_checker u_blt3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

FILE: tb/tb_bresenham_line_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_3d: stream-level test of the 3D line generator
// A short table of directed requests (degenerate lines, extreme points,
// every major axis, ties, steps with no line, restart of a running line)
// is followed by random lines, broken sequences and junk steps. Each
// accepted request runs through a local line predictor; points coming
// out are matched in order against the predicted ones.
// ----------------------------------------------------------------------------
module tb_bresenham_line_3d;
   import blt3_pkg::*;

   localparam int NumItems  = 600;
   localparam int IdleLimit = 2000;
   localparam int TailWait  = 8;
   localparam int MaxPrints = 30;

   // one emitted voxel
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic [15:0] mark;
      logic        last;
   } voxel_type;

   // how a directed row is checked
   typedef enum logic [1:0] {
      ChkModel = 2'd0,
      ChkNone  = 2'd1,
      ChkPoint = 2'd2
   } chk_type;

   typedef struct packed {
      logic        op;
      logic [15:0] xs;
      logic [15:0] ys;
      logic [15:0] zs;
      logic [15:0] xe;
      logic [15:0] ye;
      logic [15:0] ze;
      logic [15:0] sym;
      chk_type     chk;
      voxel_type   want;
   } stim_row_type;

   localparam voxel_type NoPt = '0;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata  = '0;
   logic [0:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tlast;

   // line predictor state
   coord_type                 line_pos [3];
   logic [DeltaBits-1:0]      line_dbl [3];
   logic [2:0]                line_down;
   axis_type                  line_major;
   logic signed [ErrBits-1:0] line_err [2];
   coord_type                 line_left;
   logic [15:0]               line_sym;
   logic                      line_active;

   voxel_type    point_q [$];
   stim_row_type dir_tab [$];

   int  n_errors    = 0;
   int  n_counted   = 0;
   int  n_starts    = 0;
   int  n_steps     = 0;
   int  n_dead      = 0;
   int  n_points    = 0;
   int  n_ends      = 0;
   int  idle_cycles = 0;
   bit  quiet       = 1'b0;

   bresenham_line_3d u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_err(input string what);
      if (n_errors < MaxPrints) $display("ERROR @%0t: %s", $time, what);
      n_errors++;
   endtask

   // step row of the directed table, payload all zero
   function automatic stim_row_type step_row(input chk_type chk);
      stim_row_type r;
      r      = '0;
      r.op   = OpStep;
      r.chk  = chk;
      r.want = NoPt;
      return r;
   endfunction

   // move one axis a unit toward its end point
   function automatic void line_move(input axis_type a);
      line_pos[a] = line_down[a] ? line_pos[a] - 1'b1 : line_pos[a] + 1'b1;
   endfunction

   // next point of the line for one request; returns 1 when a point is emitted
   function automatic bit line_next(input logic op, input logic [111:0] data,
                                    output voxel_type pt);
      coord_type s [3];
      coord_type e [3];
      coord_type d [3];
      axis_type  minor [2];
      int        j;
      pt = NoPt;
      if (op == OpStart) begin
         for (int k = 0; k < 3; k++) begin
            s[k] = data[k*16 +: 16];
            e[k] = data[(k+3)*16 +: 16];
            line_down[k] = e[k] < s[k];
            d[k] = line_down[k] ? s[k] - e[k] : e[k] - s[k];
            line_dbl[k] = {d[k], 1'b0};
            line_pos[k] = s[k];
         end
         line_sym = data[96 +: 16];
         if (d[0] >= d[1] && d[0] >= d[2]) line_major = AxisX;
         else if (d[1] >= d[2]) line_major = AxisY;
         else line_major = AxisZ;
         line_left = d[line_major];
         j = 0;
         for (int a = 0; a < 3; a++) begin
            if (a != int'(line_major)) begin
               line_err[j] = $signed({2'b00, line_dbl[a]}) - $signed({3'b000, d[line_major]});
               j++;
            end
         end
      end else begin
         if (!line_active) return 1'b0;
         j = 0;
         for (int a = 0; a < 3; a++) begin
            if (a != int'(line_major)) begin
               minor[j] = axis_type'(a);
               j++;
            end
         end
         // minor axes first, then the major axis
         for (int k = 0; k < 2; k++) begin
            if (line_err[k] > 0) begin
               line_move(minor[k]);
               line_err[k] = line_err[k] - $signed({2'b00, line_dbl[line_major]});
            end
            line_err[k] = line_err[k] + $signed({2'b00, line_dbl[minor[k]]});
         end
         line_move(line_major);
         line_left = line_left - 1'b1;
      end
      line_active = line_left != 0;
      pt = '{line_pos[0], line_pos[1], line_pos[2], line_sym, !line_active};
      return 1'b1;
   endfunction

   // one request transfer, with a random gap in front
   task automatic send_req(input logic op, input logic [111:0] data,
                           input chk_type chk, input voxel_type want);
      voxel_type pt;
      bit        hit;
      while (!quiet && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit = line_next(op, data, pt);
      if (op == OpStart) n_starts++;
      else if (hit) n_steps++;
      else n_dead++;
      if (hit) n_counted++;
      case (chk)
         ChkModel: if (hit) point_q.push_back(pt);
         ChkPoint: point_q.push_back(want);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // hold the sender until every predicted point is out
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (point_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [111:0] junk_data();
      logic [127:0] r;
      r = {$urandom, $urandom, $urandom, $urandom};
      return r[111:0];
   endfunction

   // random line: start, then steps; wide lines are cut short on purpose
   task automatic run_line(input bit wide);
      coord_type s [3];
      coord_type e [3];
      int        span;
      int        n;
      int        offs [3];
      for (int k = 0; k < 3; k++) begin
         s[k] = coord_type'($urandom);
         span = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
         offs[k] = $urandom_range(span);
         e[k] = $urandom_range(1) ? s[k] + coord_type'(offs[k])
                                  : s[k] - coord_type'(offs[k]);
         if (wide) e[k] = coord_type'($urandom);
      end
      // tie on the first two axes now and then
      if ($urandom_range(4) == 0) e[1] = ($urandom_range(1)) ? s[1] + coord_type'(offs[0])
                                                             : s[1] - coord_type'(offs[0]);
      send_req(OpStart, {coord_type'($urandom), e[2], e[1], e[0], s[2], s[1], s[0]},
               ChkModel, NoPt);
      n = line_left;
      if (wide) n = $urandom_range(4);
      else if ($urandom_range(4) == 0 && n > 0) n = $urandom_range(n - 1);
      else if ($urandom_range(6) == 0) n = n + $urandom_range(1, 2);
      repeat (n) send_req(OpStep, junk_data(), ChkModel, NoPt);
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
   end

   // result checker
   always @(posedge clock) begin : check_points
      voxel_type want;
      voxel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tdata[63:48],
                 rsp_tlast};
         n_points++;
         if (rsp_tlast) n_ends++;
         if (point_q.size() == 0) begin
            report_err($sformatf("unexpected point %h", got));
         end else begin
            want = point_q.pop_front();
            if (got.x !== want.x)
               report_err($sformatf("pt_x got %h want %h", got.x, want.x));
            if (got.y !== want.y)
               report_err($sformatf("pt_y got %h want %h", got.y, want.y));
            if (got.z !== want.z)
               report_err($sformatf("pt_z got %h want %h", got.z, want.z));
            if (got.mark !== want.mark)
               report_err($sformatf("mark got %h want %h", got.mark, want.mark));
            if (got.last !== want.last)
               report_err($sformatf("last got %b want %b", got.last, want.last));
         end
      end
   end

   // watchdog: no transfer on either side for too long
   initial begin
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      stim_row_type row;
      line_active = 1'b0;
      line_left   = '0;

      // directed table
      dir_tab.push_back('{OpStep, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                          ChkNone, NoPt});
      dir_tab.push_back('{OpStart, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                          ChkPoint, '{16'h0, 16'h0, 16'h0, 16'h0, 1'b1}});
      dir_tab.push_back('{OpStart, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                          16'hffff, 16'hffff, ChkPoint,
                          '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1}});
      dir_tab.push_back('{OpStep, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                          16'hffff, 16'hffff, ChkNone, NoPt});
      // x major, rising
      dir_tab.push_back('{OpStart, 16'h0, 16'h0, 16'h0, 16'h3, 16'h1, 16'h2, 16'h1234,
                          ChkPoint, '{16'h0, 16'h0, 16'h0, 16'h1234, 1'b0}});
      repeat (3) dir_tab.push_back(step_row(ChkModel));
      dir_tab.push_back(step_row(ChkNone));
      // y major, falling on x and y
      dir_tab.push_back('{OpStart, 16'h0100, 16'h0200, 16'h0300, 16'h00fe, 16'h01fb,
                          16'h0301, 16'ha5a5, ChkPoint,
                          '{16'h0100, 16'h0200, 16'h0300, 16'ha5a5, 1'b0}});
      repeat (5) dir_tab.push_back(step_row(ChkModel));
      // z major
      dir_tab.push_back('{OpStart, 16'hffff, 16'h0, 16'h8000, 16'hfffe, 16'h1, 16'h8002,
                          16'h5a5a, ChkPoint, '{16'hffff, 16'h0, 16'h8000, 16'h5a5a, 1'b0}});
      repeat (2) dir_tab.push_back(step_row(ChkModel));
      // x and y tie: x wins
      dir_tab.push_back('{OpStart, 16'h10, 16'h10, 16'h10, 16'h12, 16'h12, 16'h10, 16'h7,
                          ChkModel, NoPt});
      repeat (2) dir_tab.push_back(step_row(ChkModel));
      // longest line, then restart while it runs
      dir_tab.push_back('{OpStart, 16'h0, 16'h0, 16'h0, 16'hffff, 16'hffff, 16'hffff,
                          16'hffff, ChkPoint, '{16'h0, 16'h0, 16'h0, 16'hffff, 1'b0}});
      dir_tab.push_back(step_row(ChkModel));
      dir_tab.push_back('{OpStart, 16'hffff, 16'h0, 16'hffff, 16'h0, 16'hffff, 16'h0,
                          16'h0, ChkPoint, '{16'hffff, 16'h0, 16'hffff, 16'h0, 1'b0}});
      dir_tab.push_back(step_row(ChkModel));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         send_req(row.op, {row.sym, row.ze, row.ye, row.xe, row.zs, row.ys, row.xs},
                  row.chk, row.want);
      end
      drain_pause();

      // random lines, broken sequences and junk steps
      n_counted = 0;
      while (n_counted < NumItems) begin
         quiet = (n_counted >= 250 && n_counted < 350);
         if (n_counted >= 450 && point_q.size() != 0 && $urandom_range(30) == 0)
            drain_pause();
         case ($urandom_range(9))
            0: run_line(1'b1);
            1: repeat ($urandom_range(1, 3)) send_req(OpStep, junk_data(), ChkModel, NoPt);
            default: run_line(1'b0);
         endcase
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (point_q.size() != 0) @(posedge clock);
      repeat (TailWait) @(posedge clock);
      if (point_q.size() != 0) report_err("points still expected at the end");

      $display("Covered %0d starts, %0d steps and %0d steps with no line running;",
               n_starts, n_steps, n_dead);
      $display("%0d points checked, %0d of them line end points.", n_points, n_ends);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/blt3_pkg.sv
rtl/core/blt3_prep.sv
rtl/core/blt3_step.sv
rtl/core/bresenham_line_3d.sv
rtl/core/blt3_checker.sv
tb/tb_bresenham_line_3d.sv
